/* rtl/core/racs_pkg.sv */
// Shared constants, types and modular helpers for the rolling window checksum.
package racs_pkg;

  localparam int unsigned WINDOW_MAX_DEF = 4096;

  localparam int unsigned CFG_LEN_W = 13;
  localparam logic [CFG_LEN_W-1:0] WINDOW_LEN_RST = 13'd4096;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_WINDOW_LEN = '0;

  localparam logic [16:0] MOD_ADLER = 17'd65521;

  localparam int unsigned OUT_DEPTH = 8;

  typedef struct packed {
    logic [31:0] checksum;
    logic        window_full;
  } result_t;

  // Reduce a value below three times the modulus.
  function automatic logic [15:0] mod_fold3(input logic [17:0] t);
    logic [17:0] m1;
    logic [17:0] m2;
    m1 = {1'b0, MOD_ADLER};
    m2 = {MOD_ADLER, 1'b0};
    priority if (t >= m2) begin
      return 16'(t - m2);
    end else if (t >= m1) begin
      return 16'(t - m1);
    end else begin
      return t[15:0];
    end
  endfunction

  // Reduce a 24-bit product: 2^16 is congruent to 15.
  function automatic logic [15:0] mul_reduce(input logic [23:0] p);
    logic [11:0] h15;
    logic [16:0] s;
    h15 = {p[23:16], 4'b0000} - {4'b0000, p[23:16]};
    s   = {1'b0, p[15:0]} + {5'b00000, h15};
    if (s >= MOD_ADLER) begin
      return 16'(s - MOD_ADLER);
    end else begin
      return s[15:0];
    end
  endfunction

endpackage

/* rtl/core/racs_in_if.sv */
// Input byte channel: valid/ready handshake with byte and restart flag.
interface racs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, data_byte, restart, input ready);
  modport sink   (input valid, data_byte, restart, output ready);
endinterface

/* rtl/core/racs_out_if.sv */
// Result channel: valid/ready handshake with checksum and window-full flag.
interface racs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;
  logic        window_full;

  modport source (output valid, checksum, window_full, input ready);
  modport sink   (input valid, checksum, window_full, output ready);
endinterface

/* rtl/core/racs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module racs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = racs_pkg::WINDOW_MAX_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read and write of the same entry returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/racs_out_fifo.sv */
// Result FIFO that decouples the checksum pipeline from the receiver.
module racs_out_fifo #(
  parameter int unsigned DEPTH = racs_pkg::OUT_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  racs_pkg::result_t          push_data_i,
  input  logic                       pop_i,
  output racs_pkg::result_t          pop_data_o,
  output logic                       valid_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  racs_pkg::result_t entry_q [DEPTH];
  logic [IDX_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [IDX_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == IDX_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == IDX_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = entry_q[rd_ptr_q];
  assign valid_o    = (count_q != '0);
  assign count_o    = count_q;

endmodule

/* rtl/core/rolling_adler_window_checksum.sv */
// Top level of the rolling Adler-style window checksum block.
//
// Usage: stream one byte per transaction on in_i (data_byte, restart). Each
// byte yields exactly one transaction on out_o: checksum holds B in bits
// 31:16 and A in bits 15:0, window_full is set once at least window_len
// bytes have arrived since the last restart. A set restart flag clears the
// sums and the fill count before its own byte is taken.
// window_len is written over the APB port at byte address 0, by the user only
// while the block is idle, which the block does not enforce; 0 acts as 1,
// values above WINDOW_MAX act as WINDOW_MAX. Throughput: one byte per cycle
// while in_i.ready is high. The window RAM read of the byte leaving the
// window lands at the accepting edge; the stage 2 registers take the
// length-times-byte product, stage 3 its modular fold, and the A/B recurrence
// then writes the sum registers and pushes the result FIFO.
// A result FIFO of OUT_DEPTH entries sits at the output; in_i.ready drops
// only when FIFO entries plus items in flight would exceed it, so a stalled
// receiver backs up the input after a few items and nothing is lost.
// Reset: window_len returns to 4096, A to 1, B to 0, fill count and write
// pointer to 0. The window RAM is not cleared: only bytes written since
// restart are ever read back.
module rolling_adler_window_checksum #(
  parameter int unsigned WINDOW_MAX = racs_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  racs_in_if.sink                             in_i,
  racs_out_if.source                          out_o,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [racs_pkg::APB_ADDR_W-1:0]     paddr_i,
  input  logic [racs_pkg::APB_DATA_W-1:0]     pwdata_i,
  output logic [racs_pkg::APB_DATA_W-1:0]     prdata_o,
  output logic                                pready_o
);

  localparam int unsigned PTR_W = $clog2(WINDOW_MAX);
  localparam int unsigned LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CNT_W = $clog2(racs_pkg::OUT_DEPTH + 1);
  localparam logic [LEN_W:0]   WMAX_X   = (LEN_W + 1)'(WINDOW_MAX);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_MAX - 1);
  localparam logic [CNT_W:0]   OCC_MAX  = (CNT_W + 1)'(racs_pkg::OUT_DEPTH);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [racs_pkg::CFG_LEN_W-1:0] window_len_q;
  logic                           cfg_hit;
  logic                           cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_hit  = (paddr_i[racs_pkg::APB_ADDR_W-1:2] == racs_pkg::REG_WINDOW_LEN);
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign prdata_o = cfg_hit ? racs_pkg::APB_DATA_W'(window_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= racs_pkg::WINDOW_LEN_RST;
    end else if (cfg_wr && cfg_hit) begin
      window_len_q <= pwdata_i[racs_pkg::CFG_LEN_W-1:0];
    end
  end

  // Effective window length, clamped to 1..WINDOW_MAX, and its residue.
  logic [LEN_W-1:0] len;
  logic [16:0]      len_x;
  logic [15:0]      len_mod;

  always_comb begin
    priority if (window_len_q == '0) begin
      len = LEN_W'(1);
    end else if (32'(window_len_q) > WINDOW_MAX) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = LEN_W'(window_len_q);
    end
  end

  assign len_x   = 17'(len);
  assign len_mod = (len_x >= racs_pkg::MOD_ADLER) ? 16'(len_x - racs_pkg::MOD_ADLER)
                                                  : len_x[15:0];

  // ---------------------------------------------------------------------
  // Stage 0: accept, fill tracking, window RAM read and write
  // ---------------------------------------------------------------------
  logic             accept;
  logic [CNT_W-1:0] fifo_count;
  logic [CNT_W:0]   occ;
  logic             s1_valid_q, s2_valid_q, s3_valid_q;

  logic [LEN_W-1:0] fill_count_q;
  logic [PTR_W-1:0] wp_q;
  logic [LEN_W-1:0] fc_eff;
  logic [LEN_W:0]   fc_inc;
  logic             roll;
  logic             full;
  logic [LEN_W:0]   wp_x;
  logic [LEN_W:0]   len_xx;
  logic [PTR_W-1:0] rd_addr;
  logic [7:0]       old_byte;

  // Credit check: never launch more items than the FIFO can absorb.
  assign occ = (CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(s1_valid_q)
             + (CNT_W + 1)'(s2_valid_q) + (CNT_W + 1)'(s3_valid_q);
  assign in_i.ready = (occ < OCC_MAX);
  assign accept     = in_i.valid && in_i.ready;

  assign fc_eff = in_i.restart ? '0 : fill_count_q;
  assign roll   = (fc_eff >= len);
  assign fc_inc = (LEN_W + 1)'(fc_eff) + 1'b1;
  assign full   = roll || (fc_inc >= (LEN_W + 1)'(len));

  // Oldest byte sits len entries behind the write pointer, modulo depth.
  assign wp_x    = (LEN_W + 1)'(wp_q);
  assign len_xx  = (LEN_W + 1)'(len);
  assign rd_addr = (wp_x >= len_xx) ? PTR_W'(wp_x - len_xx)
                                    : PTR_W'(wp_x + WMAX_X - len_xx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_count_q <= '0;
      wp_q         <= '0;
    end else if (accept) begin
      fill_count_q <= roll ? fc_eff : LEN_W'(fc_inc);
      wp_q         <= (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
    end
  end

  racs_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_MAX)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (in_i.data_byte),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (old_byte)
  );

  // ---------------------------------------------------------------------
  // Stage 1: oldest byte available; multiply by the length residue
  // ---------------------------------------------------------------------
  logic [7:0]  s1_d_q;
  logic        s1_restart_q, s1_roll_q, s1_full_q;
  logic [23:0] s1_prod;
  logic [16:0] s1_a_add;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_d_q       <= in_i.data_byte;
      s1_restart_q <= in_i.restart;
      s1_roll_q    <= roll;
      s1_full_q    <= full;
    end
  end

  assign s1_prod  = {8'b0, len_mod} * {16'b0, old_byte};
  // A increment: d, or d - old when rolling, kept non-negative by adding the modulus.
  assign s1_a_add = s1_roll_q ? 17'(s1_d_q) + racs_pkg::MOD_ADLER - 17'(old_byte)
                              : 17'(s1_d_q);

  // ---------------------------------------------------------------------
  // Stage 2: fold the product; form the B correction (-1 - L*old)
  // ---------------------------------------------------------------------
  logic [23:0] s2_prod_q;
  logic [16:0] s2_a_add_q;
  logic        s2_restart_q, s2_roll_q, s2_full_q;
  logic [15:0] s2_lo;
  logic [15:0] s2_b_add;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_prod_q    <= s1_prod;
      s2_a_add_q   <= s1_a_add;
      s2_restart_q <= s1_restart_q;
      s2_roll_q    <= s1_roll_q;
      s2_full_q    <= s1_full_q;
    end
  end

  assign s2_lo    = racs_pkg::mul_reduce(s2_prod_q);
  assign s2_b_add = s2_roll_q ? 16'(racs_pkg::MOD_ADLER - 17'd1 - 17'(s2_lo)) : '0;

  // ---------------------------------------------------------------------
  // Stage 3: A/B recurrence, one item per cycle
  // ---------------------------------------------------------------------
  logic [16:0] s3_a_add_q;
  logic [15:0] s3_b_add_q;
  logic        s3_restart_q, s3_full_q;
  logic [15:0] sum_a_q, sum_b_q;
  logic [15:0] a_base, b_base, a_new, b_new;
  racs_pkg::result_t res;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_a_add_q   <= s2_a_add_q;
      s3_b_add_q   <= s2_b_add;
      s3_restart_q <= s2_restart_q;
      s3_full_q    <= s2_full_q;
    end
  end

  assign a_base = s3_restart_q ? 16'd1 : sum_a_q;
  assign b_base = s3_restart_q ? 16'd0 : sum_b_q;
  assign a_new  = racs_pkg::mod_fold3(18'(a_base) + 18'(s3_a_add_q));
  assign b_new  = racs_pkg::mod_fold3(18'(b_base) + 18'(a_new) + 18'(s3_b_add_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q <= 16'd1;
      sum_b_q <= 16'd0;
    end else if (s3_valid_q) begin
      sum_a_q <= a_new;
      sum_b_q <= b_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  assign res.checksum    = {b_new, a_new};
  assign res.window_full = s3_full_q;

  // ---------------------------------------------------------------------
  // Result FIFO: hold results while the receiver stalls
  // ---------------------------------------------------------------------
  racs_pkg::result_t fifo_data;
  logic              fifo_valid;

  racs_out_fifo #(
    .DEPTH (racs_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_valid_q),
    .push_data_i (res),
    .pop_i       (out_o.valid && out_o.ready),
    .pop_data_o  (fifo_data),
    .valid_o     (fifo_valid),
    .count_o     (fifo_count)
  );

  assign out_o.valid       = fifo_valid;
  assign out_o.checksum    = fifo_data.checksum;
  assign out_o.window_full = fifo_data.window_full;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_sums_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, sum_a_q} < racs_pkg::MOD_ADLER) && ({1'b0, sum_b_q} < racs_pkg::MOD_ADLER))
    else $error("checksum sums not reduced below modulus");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OCC_MAX)
    else $error("items in flight exceed result FIFO space");

  a_roll_holds_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && roll) |=> $stable(fill_count_q))
    else $error("fill count moved while rolling");

  a_restart_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.restart) |=> (fill_count_q == LEN_W'(1)))
    else $error("restart did not restart the fill count");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the rolling Adler-style window checksum block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import racs_pkg::*;

  localparam int unsigned WMAX    = WINDOW_MAX_DEF;
  localparam int unsigned IDX_W   = $clog2(WMAX);
  localparam int unsigned MODULUS = 32'(MOD_ADLER);
  localparam logic [APB_ADDR_W-1:0] LEN_ADDR = {REG_WINDOW_LEN, 2'b00};
  // Still running this long after the start means the block hung.
  localparam int unsigned RUN_LIMIT_NS = 30_000_000;

  logic clk_i;
  logic rst_ni;
  logic psel_i;
  logic penable_i;
  logic pwrite_i;
  logic [APB_ADDR_W-1:0] paddr_i;
  logic [APB_DATA_W-1:0] pwdata_i;
  logic [APB_DATA_W-1:0] prdata_o;
  logic pready_o;

  racs_in_if  byte_ch ();
  racs_out_if sum_ch ();

  rolling_adler_window_checksum dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (byte_ch),
    .out_o     (sum_ch),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  // Shadow copy of the block state, advanced once per accepted byte.
  logic [7:0]  win_bytes [WMAX];
  int unsigned wr_ptr;
  int unsigned fill_cnt;
  int unsigned sum_a;
  int unsigned sum_b;
  logic [CFG_LEN_W-1:0] window_len_reg;

  // Checksums still owed by the block, oldest first.
  result_t     pending_sums [$];
  int unsigned errors;
  // Random gaps on the byte side and stalls on the result side.
  bit          idling;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block stops answering.
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 40) begin
      $display("%0t ns mismatch %s: got %h, want %h", $realtime, what, got, want);
    end
    errors++;
  endtask

  // Advance the shadow state by one byte and return the checksum it yields.
  function automatic result_t window_sum_step(input logic [7:0] d, input logic rs);
    int unsigned len;
    int unsigned old;
    int unsigned lo;
    int unsigned a;
    result_t r;
    // Zero acts as one, anything past the store depth acts as the depth.
    if (window_len_reg == 0) begin
      len = 1;
    end else if (32'(window_len_reg) > WMAX) begin
      len = WMAX;
    end else begin
      len = 32'(window_len_reg);
    end
    if (rs) begin
      sum_a    = 1;
      sum_b    = 0;
      fill_cnt = 0;
    end
    if (fill_cnt >= len) begin
      // Window full: drop the byte written len transactions ago, add the new one.
      old   = 32'(win_bytes[IDX_W'((wr_ptr + WMAX - len) % WMAX)]);
      lo    = ((len % MODULUS) * old) % MODULUS;
      a     = (sum_a + d + MODULUS - old) % MODULUS;
      sum_b = (sum_b + a + 2 * MODULUS - 1 - lo) % MODULUS;
      sum_a = a;
    end else begin
      sum_a = (sum_a + d) % MODULUS;
      sum_b = (sum_b + sum_a) % MODULUS;
      fill_cnt++;
    end
    win_bytes[IDX_W'(wr_ptr)] = d;
    wr_ptr = (wr_ptr + 1) % WMAX;
    r.checksum    = {sum_b[15:0], sum_a[15:0]};
    r.window_full = (fill_cnt >= len);
    return r;
  endfunction

  // Send one byte transaction, with an optional gap ahead of it; valid stays
  // high afterwards so back-to-back bytes go out without a gap.
  task automatic send_byte(input logic [7:0] d, input logic rs);
    int unsigned gap;
    if (idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      repeat (gap) begin
        @(negedge clk_i);
        byte_ch.valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= d;
    byte_ch.restart   <= rs;
    @(posedge clk_i);
    while (!byte_ch.ready) begin
      @(posedge clk_i);
    end
    pending_sums.push_back(window_sum_step(d, rs));
  endtask

  task automatic send_random_byte(input logic rs);
    logic [7:0] d;
    // Lean on the byte extremes now and then.
    if ($urandom_range(0, 9) == 0) begin
      d = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else begin
      d = 8'($urandom_range(0, 255));
    end
    send_byte(d, rs);
  endtask

  // Drop valid and hold until every owed checksum has come back.
  task automatic drain;
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic apb_xfer(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= wr;
    paddr_i   <= LEN_ADDR;
    pwdata_i  <= wdata;
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) begin
      @(posedge clk_i);
    end
    rdata = prdata_o;
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
  endtask

  task automatic check_window_len;
    logic [APB_DATA_W-1:0] rd;
    apb_xfer(1'b0, '0, rd);
    if (rd !== APB_DATA_W'(window_len_reg)) begin
      report_mismatch("window_len readback", rd, APB_DATA_W'(window_len_reg));
    end
  endtask

  // Write window_len only once the block is idle, then read it back.
  task automatic set_window_len(input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    drain;
    apb_xfer(1'b1, value, rd);
    window_len_reg = value[CFG_LEN_W-1:0];
    check_window_len;
  endtask

  // Score every result transaction against the oldest owed checksum.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && sum_ch.valid && sum_ch.ready) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("result with nothing owed", sum_ch.checksum, '0);
      end else begin
        want = pending_sums.pop_front();
        if (sum_ch.checksum !== want.checksum) begin
          report_mismatch("checksum", sum_ch.checksum, want.checksum);
        end
        if (sum_ch.window_full !== want.window_full) begin
          report_mismatch("window_full", 32'(sum_ch.window_full), 32'(want.window_full));
        end
      end
    end
  end

  // Result-side backpressure: random stall bursts while idling is on.
  initial begin
    int unsigned rx_hold;
    rx_hold      = 0;
    sum_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0) begin
        rx_hold--;
        sum_ch.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 6) == 0) begin
        rx_hold = $urandom_range(0, 10);
        sum_ch.ready <= 1'b0;
      end else begin
        sum_ch.ready <= 1'b1;
      end
    end
  end

  // Reset length is the full store: read it back, then fill part of the window.
  task automatic test_reset_length;
    check_window_len;
    repeat (48) begin
      send_random_byte(1'b0);
    end
  endtask

  // Byte extremes, restart, zero length acting as one, tiny windows.
  task automatic test_directed;
    set_window_len(32'd0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    set_window_len(32'd3);
    send_byte(8'hFF, 1'b1);
    repeat (4) begin
      send_byte(8'hFF, 1'b0);
    end
    repeat (3) begin
      send_byte(8'h00, 1'b0);
    end
    send_byte(8'h00, 1'b1);
    set_window_len(32'd1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Change the length mid-stream without restart, both down and up, and
  // write values past the store depth including all ones.
  task automatic test_length_change;
    set_window_len(32'd8);
    send_random_byte(1'b1);
    repeat (11) begin
      send_random_byte(1'b0);
    end
    set_window_len(32'd3);
    repeat (6) begin
      send_random_byte(1'b0);
    end
    set_window_len(32'd20);
    repeat (25) begin
      send_random_byte(1'b0);
    end
    set_window_len(32'hFFFF_FFFF);
    repeat (5) begin
      send_random_byte(1'b0);
    end
    set_window_len(32'd4097);
    send_random_byte(1'b1);
    repeat (4) begin
      send_random_byte(1'b0);
    end
  endtask

  // Phases of random bytes, each under its own window length and idling mode.
  task automatic test_random_phases;
    int unsigned sent;
    int unsigned n;
    int unsigned pick;
    logic [CFG_LEN_W-1:0] len;
    logic [APB_DATA_W-1:0] value;
    sent = 0;
    while (sent < 1000) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        len = CFG_LEN_W'($urandom_range(1, 16));
      end else if (pick < 9) begin
        len = CFG_LEN_W'($urandom_range(17, 300));
      end else begin
        case ($urandom_range(0, 4))
          0: begin
            len = '0;
          end
          1: begin
            len = CFG_LEN_W'(WMAX);
          end
          2: begin
            len = CFG_LEN_W'(WMAX + 1);
          end
          3: begin
            len = '1;
          end
          default: begin
            len = CFG_LEN_W'(2);
          end
        endcase
      end
      // Junk in the unused upper bits must be ignored.
      value = {$urandom_range(0, 1) ? 19'($urandom) : 19'd0, len};
      set_window_len(value);
      idling = ($urandom_range(0, 3) != 0);
      n = $urandom_range(40, 160);
      // Most phases start clean; the rest carry the old stream over.
      send_random_byte($urandom_range(0, 3) != 0);
      repeat (n - 1) begin
        send_random_byte($urandom_range(0, 59) == 0);
      end
      sent += n;
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_back_to_back;
    set_window_len(32'd7);
    idling = 1'b0;
    send_random_byte(1'b1);
    repeat (299) begin
      send_random_byte($urandom_range(0, 49) == 0);
    end
  endtask

  initial begin
    errors            = 0;
    idling            = 1'b1;
    wr_ptr            = 0;
    fill_cnt          = 0;
    sum_a             = 1;
    sum_b             = 0;
    window_len_reg    = WINDOW_LEN_RST;
    rst_ni            = 1'b0;
    psel_i            = 1'b0;
    penable_i         = 1'b0;
    pwrite_i          = 1'b0;
    paddr_i           = '0;
    pwdata_i          = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.restart   = 1'b0;
    repeat (4) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_length;
    test_directed;
    test_length_change;
    test_random_phases;
    test_back_to_back;

    // Let the pipeline settle so a stray extra result would still show up.
    drain;
    repeat (12) begin
      @(posedge clk_i);
    end
    if (errors == 0 && pending_sums.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/racs_pkg.sv
rtl/core/racs_in_if.sv
rtl/core/racs_out_if.sv
rtl/core/racs_ram.sv
rtl/core/racs_out_fifo.sv
rtl/core/rolling_adler_window_checksum.sv
tb/tb.sv
